// ===== design/random_chain_scission_step_macros.svh =====
// Assertion macros for the chain scission block.
// Used by the checker module; depends on clk and rst_n in the including scope.
`ifndef RANDOM_CHAIN_SCISSION_STEP_MACROS_SVH
`define RANDOM_CHAIN_SCISSION_STEP_MACROS_SVH

// same-cycle implication
`define RCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rcs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
// No dependencies.
package rcs_pkg;

    localparam int MAX_BONDS  = 1024;
    localparam int LIST_AW    = 10;
    localparam int HIST_DEPTH = MAX_BONDS + 1;
    localparam int HIST_AW    = 11;
    localparam int LEN_W      = 11;
    localparam int RAND_W     = 31;

    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_DEGRADE = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;

    localparam logic REG_INITIAL = 1'b0;
    localparam logic REG_MIN     = 1'b1;

    localparam logic [1:0] HSEL_LEN   = 2'd0;
    localparam logic [1:0] HSEL_LEFT  = 2'd1;
    localparam logic [1:0] HSEL_RIGHT = 2'd2;

    typedef struct packed {
        logic take_in;
        logic clr_start;
        logic clr_step;
        logic clr_one;
        logic mod_start_p;
        logic mod_start_c;
        logic len_rd;
        logic len_load;
        logic cut_load;
        logic mul_load;
        logic left_write;
        logic shift_start;
        logic shift_step;
        logic shift_end;
        logic append;
        logic hist_start;
        logic hist_rd;
        logic hist_wr;
        logic hist_next;
        logic query_rd;
        logic query_load;
        logic finish;
    } rcs_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       clr_last;
        logic       mod_done;
        logic       count_zero;
        logic       len_gt1;
        logic       left_short;
        logic       shift_done;
        logic       hist_last;
        logic       hidx_ok;
        logic       out_busy;
    } rcs_sts_t;

endpackage

// ===== design/rcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/rcs_mod.sv =====
// Iterative restoring modulo unit, one dividend bit per cycle.
// Depends on rcs_pkg.
module rcs_mod
    import rcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAND_W-1:0] dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic              done,
    output logic [LEN_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(RAND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(RAND_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAND_W-1:0] quo_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  div_reg;
    logic [LEN_W:0]    shifted;
    logic [LEN_W:0]    diff;
    logic [LEN_W-1:0]  rem_next;

    assign shifted  = {rem_reg, quo_reg[RAND_W-1]};
    assign diff     = shifted - {1'b0, div_reg};
    assign rem_next = (shifted >= {1'b0, div_reg}) ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[RAND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/rcs_datapath.sv =====
// Datapath: chain list and histogram memories, modulo unit, counters, result register.
// Depends on rcs_pkg, rcs_ram and rcs_mod.
module rcs_datapath
    import rcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic [1:0]        kind,
    input  logic [RAND_W-1:0] chain_random,
    input  logic [RAND_W-1:0] cut_random,
    input  logic [10:0]       hist_index,
    input  rcs_cmd_t          cmd,
    output rcs_sts_t          sts,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              status,
    output logic [10:0]       picked_bonds,
    output logic [9:0]        left_bonds,
    output logic [9:0]        right_bonds,
    output logic [1:0]        monomers_released,
    output logic [11:0]       released_total,
    output logic [10:0]       chains_left,
    output logic [10:0]       cuts_done,
    output logic [20:0]       second_moment,
    output logic              fully_degraded,
    output logic [11:0]       hist_count
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BONDS);

    logic [LEN_W-1:0]  init_reg, minb_reg;
    logic [1:0]        kind_reg;
    logic [RAND_W-1:0] rc_reg, rk_reg;
    logic [10:0]       hidx_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [11:0]       released_reg;
    logic [10:0]       cuts_reg;
    logic [20:0]       moment_reg;
    logic              empty_reg;
    logic [LIST_AW-1:0] p_reg;
    logic [LEN_W-1:0]  len_reg, c_reg;
    logic [9:0]        left_reg, right_reg;
    logic [20:0]       dec_reg;
    logic [1:0]        rel_reg;
    logic              ok_reg;
    logic [11:0]       hq_reg;
    logic [HIST_AW-1:0] clr_addr_reg;
    logic [LEN_W-1:0]  si_reg;
    logic              pend_reg;
    logic [LIST_AW-1:0] rd_addr_reg;
    logic [1:0]        hsel_reg;
    logic              out_valid_reg;

    logic [LEN_W-1:0]  minb_eff, sat_len, c_val, ma, mb, count_m1;
    logic [21:0]       prod;
    logic              mod_start, mod_done;
    logic [RAND_W-1:0] mod_dvd;
    logic [LEN_W-1:0]  mod_dvs, mod_rem;
    logic              shift_more, right_keep, is_restart;
    logic [HIST_AW-1:0] bin;

    logic               c_we, c_re;
    logic [LIST_AW-1:0] c_waddr, c_raddr;
    logic [LEN_W-1:0]   c_wdata, c_rdata;
    logic               h_we, h_re;
    logic [HIST_AW-1:0] h_waddr, h_raddr;
    logic [11:0]        h_wdata, h_rdata;

    logic [LEN_W-1:0] count_next;
    logic [11:0]      released_next;
    logic [10:0]      cuts_next;
    logic [20:0]      moment_next;
    logic             empty_next;

    assign minb_eff   = (minb_reg == '0) ? LEN_W'(1) : minb_reg;
    assign sat_len    = (init_reg == '0) ? LEN_W'(1) :
                        ((init_reg > MAX_LEN) ? MAX_LEN : init_reg);
    assign is_restart = (kind_reg == KIND_RESTART);
    assign c_val      = (len_reg > LEN_W'(1)) ? (mod_rem + 1'b1) : LEN_W'(1);
    assign ma         = is_restart ? (len_reg + 1'b1) : c_reg;
    assign mb         = is_restart ? (len_reg + 1'b1) : ({1'b0, right_reg} + 1'b1);
    assign prod       = ma * mb;
    assign shift_more = (si_reg < count_reg);
    assign right_keep = ({1'b0, right_reg} >= minb_eff);
    assign count_m1   = count_reg - 1'b1;

    always_comb
    begin
        case (hsel_reg)
            HSEL_LEN:   bin = len_reg;
            HSEL_LEFT:  bin = {1'b0, left_reg};
            HSEL_RIGHT: bin = {1'b0, right_reg};
            default:    bin = '0;
        endcase
    end

    assign mod_start = cmd.mod_start_p | cmd.mod_start_c;
    assign mod_dvd   = cmd.mod_start_p ? rc_reg : rk_reg;
    assign mod_dvs   = cmd.mod_start_p ? count_reg : (len_reg - 1'b1);

    rcs_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dvd),
        .divisor   (mod_dvs),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // chain list ports
    always_comb
    begin
        c_we    = 1'b0;
        c_waddr = '0;
        c_wdata = '0;
        if (cmd.left_write)
        begin
            c_we    = 1'b1;
            c_waddr = p_reg;
            c_wdata = {1'b0, left_reg};
        end
        else if (cmd.shift_step && pend_reg)
        begin
            c_we    = 1'b1;
            c_waddr = rd_addr_reg - 1'b1;
            c_wdata = c_rdata;
        end
        else if (cmd.append && right_keep && (count_reg < MAX_LEN))
        begin
            c_we    = 1'b1;
            c_waddr = count_reg[LIST_AW-1:0];
            c_wdata = {1'b0, right_reg};
        end
        else if (cmd.finish && is_restart)
        begin
            c_we    = 1'b1;
            c_waddr = '0;
            c_wdata = len_reg;
        end
    end

    assign c_re    = cmd.len_rd | (cmd.shift_step && shift_more);
    assign c_raddr = cmd.len_rd ? mod_rem[LIST_AW-1:0] : si_reg[LIST_AW-1:0];

    rcs_ram #(.WIDTH(LEN_W), .DEPTH(MAX_BONDS)) u_list (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // histogram ports
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = bin;
        h_wdata = '0;
        if (cmd.clr_step)
        begin
            h_we    = 1'b1;
            h_waddr = clr_addr_reg;
            h_wdata = (cmd.clr_one && (clr_addr_reg == len_reg)) ? 12'd1 : 12'd0;
        end
        else if (cmd.hist_wr)
        begin
            h_we    = 1'b1;
            h_wdata = h_rdata + ((hsel_reg == HSEL_LEN) ? 12'hFFF : 12'd1);
        end
    end

    assign h_re    = cmd.hist_rd | cmd.query_rd;
    assign h_raddr = cmd.query_rd ? hidx_reg : bin;

    rcs_ram #(.WIDTH(12), .DEPTH(HIST_DEPTH)) u_hist (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // state after the transaction
    always_comb
    begin
        count_next    = count_reg;
        released_next = released_reg;
        cuts_next     = cuts_reg;
        moment_next   = moment_reg;
        empty_next    = empty_reg;
        if (is_restart)
        begin
            count_next    = LEN_W'(1);
            released_next = '0;
            cuts_next     = '0;
            moment_next   = prod[20:0];
            empty_next    = 1'b0;
        end
        else if (kind_reg == KIND_DEGRADE && ok_reg)
        begin
            released_next = released_reg + {10'd0, rel_reg};
            cuts_next     = cuts_reg + 1'b1;
            moment_next   = moment_reg - dec_reg;
            empty_next    = empty_reg | (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= LEN_W'(1023);
            minb_reg      <= LEN_W'(1);
            count_reg     <= '0;
            released_reg  <= '0;
            cuts_reg      <= '0;
            moment_reg    <= '0;
            empty_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_INITIAL)
                begin
                    init_reg <= cfg_data;
                end
                else
                begin
                    minb_reg <= cfg_data;
                end
            end
            if (cmd.clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.shift_start)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.shift_step)
            begin
                pend_reg <= shift_more;
            end
            if (cmd.shift_end)
            begin
                count_reg <= count_m1;
            end
            else if (cmd.append && right_keep && (count_reg < MAX_LEN))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            if (cmd.finish)
            begin
                released_reg  <= released_next;
                cuts_reg      <= cuts_next;
                moment_reg    <= moment_next;
                empty_reg     <= empty_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            kind_reg <= kind;
            rc_reg   <= chain_random;
            rk_reg   <= cut_random;
            hidx_reg <= hist_index;
            rel_reg  <= '0;
            ok_reg   <= 1'b0;
            hq_reg   <= '0;
        end
        if (cmd.clr_start)
        begin
            len_reg <= sat_len;
        end
        if (cmd.len_rd)
        begin
            p_reg  <= mod_rem[LIST_AW-1:0];
            ok_reg <= 1'b1;
        end
        if (cmd.len_load)
        begin
            len_reg <= (c_rdata == '0) ? LEN_W'(1) : c_rdata;
        end
        if (cmd.cut_load)
        begin
            c_reg     <= c_val;
            left_reg  <= 10'(c_val - 1'b1);
            right_reg <= 10'(len_reg - c_val);
        end
        if (cmd.mul_load)
        begin
            dec_reg <= {prod[19:0], 1'b0};
        end
        if (cmd.shift_start)
        begin
            si_reg <= {1'b0, p_reg} + 1'b1;
        end
        else if (cmd.shift_step && shift_more)
        begin
            si_reg      <= si_reg + 1'b1;
            rd_addr_reg <= si_reg[LIST_AW-1:0];
        end
        if (cmd.shift_end)
        begin
            rel_reg <= rel_reg + 1'b1;
        end
        else if (cmd.append && !right_keep)
        begin
            rel_reg <= rel_reg + 1'b1;
        end
        if (cmd.hist_start)
        begin
            hsel_reg <= HSEL_LEN;
        end
        else if (cmd.hist_next)
        begin
            hsel_reg <= hsel_reg + 1'b1;
        end
        if (cmd.query_load)
        begin
            hq_reg <= h_rdata;
        end
        if (cmd.finish)
        begin
            status            <= (kind_reg == KIND_DEGRADE) && !ok_reg;
            picked_bonds      <= ok_reg ? len_reg : '0;
            left_bonds        <= ok_reg ? left_reg : '0;
            right_bonds       <= ok_reg ? right_reg : '0;
            monomers_released <= ok_reg ? rel_reg : '0;
            released_total    <= released_next;
            chains_left       <= count_next;
            cuts_done         <= cuts_next;
            second_moment     <= moment_next;
            fully_degraded    <= empty_next;
            hist_count        <= hq_reg;
        end
    end

    assign out_valid = out_valid_reg;

    assign sts.kind       = kind_reg;
    assign sts.clr_last   = (clr_addr_reg == HIST_AW'(HIST_DEPTH - 1));
    assign sts.mod_done   = mod_done;
    assign sts.count_zero = (count_reg == '0);
    assign sts.len_gt1    = (len_reg > LEN_W'(1));
    assign sts.left_short = ({1'b0, left_reg} < minb_eff);
    assign sts.shift_done = !shift_more && !pend_reg;
    assign sts.hist_last  = (hsel_reg == HSEL_RIGHT);
    assign sts.hidx_ok    = (hidx_reg <= 11'(MAX_BONDS));
    assign sts.out_busy   = out_valid_reg && !out_ready;

endmodule

// ===== design/rcs_ctrl.sv =====
// Controller state machine sequencing one transaction through the datapath.
// Depends on rcs_pkg.
module rcs_ctrl
    import rcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rcs_sts_t sts,
    output rcs_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_RESTART  = 4'd3;
    localparam logic [3:0] S_MOD1     = 4'd4;
    localparam logic [3:0] S_LENWAIT  = 4'd5;
    localparam logic [3:0] S_CUTSTART = 4'd6;
    localparam logic [3:0] S_MOD2     = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_SHIFT    = 4'd9;
    localparam logic [3:0] S_APPEND   = 4'd10;
    localparam logic [3:0] S_HRD      = 4'd11;
    localparam logic [3:0] S_HWR      = 4'd12;
    localparam logic [3:0] S_QWAIT    = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.kind)
                    KIND_RESTART:
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = S_RESTART;
                    end
                    KIND_DEGRADE:
                    begin
                        if (sts.count_zero)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.mod_start_p = 1'b1;
                            state_next      = S_MOD1;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (sts.hidx_ok)
                        begin
                            cmd.query_rd = 1'b1;
                            state_next   = S_QWAIT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RESTART:
            begin
                cmd.clr_step = 1'b1;
                cmd.clr_one  = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_MOD1:
            begin
                if (sts.mod_done)
                begin
                    cmd.len_rd = 1'b1;
                    state_next = S_LENWAIT;
                end
            end
            S_LENWAIT:
            begin
                cmd.len_load = 1'b1;
                state_next   = S_CUTSTART;
            end
            S_CUTSTART:
            begin
                if (sts.len_gt1)
                begin
                    cmd.mod_start_c = 1'b1;
                    state_next      = S_MOD2;
                end
                else
                begin
                    cmd.cut_load = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MOD2:
            begin
                if (sts.mod_done)
                begin
                    cmd.cut_load = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                if (sts.left_short)
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    cmd.left_write = 1'b1;
                    state_next     = S_APPEND;
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    cmd.shift_end = 1'b1;
                    state_next    = S_APPEND;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_APPEND:
            begin
                cmd.append     = 1'b1;
                cmd.hist_start = 1'b1;
                state_next     = S_HRD;
            end
            S_HRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_HWR;
            end
            S_HWR:
            begin
                cmd.hist_wr = 1'b1;
                if (sts.hist_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.hist_next = 1'b1;
                    state_next    = S_HRD;
                end
            end
            S_QWAIT:
            begin
                cmd.query_load = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/random_chain_scission_step.sv =====
// Chain scission block: one result per transaction, one transaction at a time.
// Degrade: its time is set by the modulo passes (the second only for a chain of more
// than one bond) and the histogram updates; an erase of a short left piece adds a move
// of the list entries behind it. Restart: a histogram clearing sweep. Results show in
// the same cycle that the next transaction can be taken; a stalled result holds the block.
// Reset runs a histogram clearing pass over every entry; no transaction is taken meanwhile.
module random_chain_scission_step
    import rcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [30:0] chain_random,
    input  logic [30:0] cut_random,
    input  logic [10:0] hist_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [10:0] picked_bonds,
    output logic [9:0]  left_bonds,
    output logic [9:0]  right_bonds,
    output logic [1:0]  monomers_released,
    output logic [11:0] released_total,
    output logic [10:0] chains_left,
    output logic [10:0] cuts_done,
    output logic [20:0] second_moment,
    output logic        fully_degraded,
    output logic [11:0] hist_count
);

    rcs_cmd_t cmd;
    rcs_sts_t sts;

    rcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rcs_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .kind              (kind),
        .chain_random      (chain_random),
        .cut_random        (cut_random),
        .hist_index        (hist_index),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .status            (status),
        .picked_bonds      (picked_bonds),
        .left_bonds        (left_bonds),
        .right_bonds       (right_bonds),
        .monomers_released (monomers_released),
        .released_total    (released_total),
        .chains_left       (chains_left),
        .cuts_done         (cuts_done),
        .second_moment     (second_moment),
        .fully_degraded    (fully_degraded),
        .hist_count        (hist_count)
    );

endmodule

// ===== design/rcs_checker.sv =====
// Port-level checker for the chain scission block, bound to the top level.
// Depends on random_chain_scission_step_macros.svh.
`include "random_chain_scission_step_macros.svh"

module rcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic [10:0] picked_bonds,
    input logic [1:0]  monomers_released,
    input logic [10:0] chains_left,
    input logic        fully_degraded
);

    `RCS_ASSERT_SAME(a_refuse_empty, out_valid && status, (chains_left == 11'd0) && fully_degraded, "refused transaction with chains left")
    `RCS_ASSERT_SAME(a_refuse_quiet, out_valid && status, (picked_bonds == 11'd0) && (monomers_released == 2'd0), "refused transaction reports a cut")
    `RCS_ASSERT_SAME(a_empty_flag, out_valid && (chains_left != 11'd0), !fully_degraded, "empty flag set with chains in list")
    `RCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before taken")

endmodule

bind random_chain_scission_step rcs_checker u_rcs_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .picked_bonds      (picked_bonds),
    .monomers_released (monomers_released),
    .chains_left       (chains_left),
    .fully_degraded    (fully_degraded)
);
